// ----- design/hab_pkg.sv -----
// hab_pkg: shared types, register indexes, reset values and microcode rom
// for the height alpha-beta filter
// no dependencies
package hab_pkg;

  // fixed field widths of the stream and configuration words
  localparam int HEIGHT_W  = 32;
  localparam int TIME_W    = 16;
  localparam int IN_DATA_W = 48;
  localparam int OUT_W     = 32;
  localparam int OUT_DATA_W = 96;
  localparam int GAIN_W    = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;

  localparam int DEF_FRAC_BITS  = 16;
  localparam int DEF_DATA_WIDTH = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd6;

  // register reset values
  localparam logic [16:0] RST_POS_GAIN  = 17'd55450;
  localparam logic [19:0] RST_VEL_GAIN  = 20'd406546;
  localparam logic [16:0] RST_VEL_SCALE = 17'd13107;
  localparam logic [16:0] RST_BLEND     = 17'd65536;
  localparam logic [30:0] RST_MAX_SPEED = 31'd32768;
  localparam logic [30:0] RST_DEADZONE  = 31'd655;
  localparam logic [15:0] RST_TIMEOUT   = 16'd16384;

  // microcode sequencer
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_WAIT = 5'd0;
  localparam logic [STEP_W-1:0] STEP_LAST = 5'd28;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MUL_RND,
    OP_ADD_SAT,
    OP_SUB_SAT,
    OP_SUB_RAW,
    OP_CLAMP,
    OP_DEADZONE,
    OP_EMIT
  } hab_op_t;

  typedef enum logic [1:0] {
    CND_NEXT,
    CND_WAIT_IN,
    CND_WAIT_OUT,
    CND_GOTO
  } hab_cond_t;

  typedef enum logic [3:0] {
    SEL_ZERO,
    SEL_PE,
    SEL_VE,
    SEL_VS,
    SEL_H,
    SEL_XP,
    SEL_IN,
    SEL_T,
    SEL_Q,
    SEL_VP
  } hab_sel_t;

  typedef enum logic [2:0] {
    G_DT,
    G_BLEND,
    G_POS,
    G_VEL,
    G_VSCALE
  } hab_gain_t;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_PE,
    DST_VE,
    DST_VS,
    DST_XP,
    DST_IN,
    DST_T
  } hab_dst_t;

  typedef struct packed {
    hab_op_t            op;
    hab_cond_t          cond;
    logic [STEP_W-1:0]  target;
    hab_sel_t           a_sel;
    hab_sel_t           b_sel;
    hab_gain_t          g_sel;
    hab_dst_t           dst;
  } hab_uword_t;

  // control rom, one word per step
  function automatic hab_uword_t hab_ucode(input logic [STEP_W-1:0] step);
    hab_uword_t w;
    w = '{OP_NOP, CND_GOTO, STEP_WAIT, SEL_ZERO, SEL_ZERO, G_DT, DST_NONE};
    case (step)
      // wait for a word
      5'd0:  w = '{OP_NOP, CND_WAIT_IN, STEP_WAIT, SEL_ZERO, SEL_ZERO, G_DT, DST_NONE};
      // prediction: xp = pe + vp * dt
      5'd1:  w = '{OP_MUL_LO, CND_NEXT, STEP_WAIT, SEL_VP, SEL_ZERO, G_DT, DST_NONE};
      5'd2:  w = '{OP_MUL_HI, CND_NEXT, STEP_WAIT, SEL_VP, SEL_ZERO, G_DT, DST_NONE};
      5'd3:  w = '{OP_MUL_RND, CND_NEXT, STEP_WAIT, SEL_ZERO, SEL_ZERO, G_DT, DST_NONE};
      5'd4:  w = '{OP_ADD_SAT, CND_NEXT, STEP_WAIT, SEL_PE, SEL_Q, G_DT, DST_XP};
      // limited last velocity, then blend into smoothed
      5'd5:  w = '{OP_CLAMP, CND_NEXT, STEP_WAIT, SEL_VE, SEL_ZERO, G_DT, DST_T};
      5'd6:  w = '{OP_DEADZONE, CND_NEXT, STEP_WAIT, SEL_T, SEL_ZERO, G_DT, DST_T};
      5'd7:  w = '{OP_SUB_RAW, CND_NEXT, STEP_WAIT, SEL_T, SEL_VS, G_DT, DST_T};
      5'd8:  w = '{OP_MUL_LO, CND_NEXT, STEP_WAIT, SEL_T, SEL_ZERO, G_BLEND, DST_NONE};
      5'd9:  w = '{OP_MUL_HI, CND_NEXT, STEP_WAIT, SEL_T, SEL_ZERO, G_BLEND, DST_NONE};
      5'd10: w = '{OP_MUL_RND, CND_NEXT, STEP_WAIT, SEL_ZERO, SEL_ZERO, G_DT, DST_NONE};
      5'd11: w = '{OP_ADD_SAT, CND_NEXT, STEP_WAIT, SEL_VS, SEL_Q, G_DT, DST_VS};
      // innovation and position correction
      5'd12: w = '{OP_SUB_SAT, CND_NEXT, STEP_WAIT, SEL_H, SEL_XP, G_DT, DST_IN};
      5'd13: w = '{OP_MUL_LO, CND_NEXT, STEP_WAIT, SEL_IN, SEL_ZERO, G_POS, DST_NONE};
      5'd14: w = '{OP_MUL_HI, CND_NEXT, STEP_WAIT, SEL_IN, SEL_ZERO, G_POS, DST_NONE};
      5'd15: w = '{OP_MUL_RND, CND_NEXT, STEP_WAIT, SEL_ZERO, SEL_ZERO, G_DT, DST_NONE};
      5'd16: w = '{OP_ADD_SAT, CND_NEXT, STEP_WAIT, SEL_XP, SEL_Q, G_DT, DST_PE};
      // velocity correction, two scalings
      5'd17: w = '{OP_MUL_LO, CND_NEXT, STEP_WAIT, SEL_IN, SEL_ZERO, G_VEL, DST_NONE};
      5'd18: w = '{OP_MUL_HI, CND_NEXT, STEP_WAIT, SEL_IN, SEL_ZERO, G_VEL, DST_NONE};
      5'd19: w = '{OP_MUL_RND, CND_NEXT, STEP_WAIT, SEL_ZERO, SEL_ZERO, G_DT, DST_NONE};
      5'd20: w = '{OP_ADD_SAT, CND_NEXT, STEP_WAIT, SEL_Q, SEL_ZERO, G_DT, DST_T};
      5'd21: w = '{OP_MUL_LO, CND_NEXT, STEP_WAIT, SEL_T, SEL_ZERO, G_VSCALE, DST_NONE};
      5'd22: w = '{OP_MUL_HI, CND_NEXT, STEP_WAIT, SEL_T, SEL_ZERO, G_VSCALE, DST_NONE};
      5'd23: w = '{OP_MUL_RND, CND_NEXT, STEP_WAIT, SEL_ZERO, SEL_ZERO, G_DT, DST_NONE};
      5'd24: w = '{OP_ADD_SAT, CND_NEXT, STEP_WAIT, SEL_Q, SEL_ZERO, G_DT, DST_T};
      5'd25: w = '{OP_ADD_SAT, CND_NEXT, STEP_WAIT, SEL_VS, SEL_T, G_DT, DST_T};
      5'd26: w = '{OP_CLAMP, CND_NEXT, STEP_WAIT, SEL_T, SEL_ZERO, G_DT, DST_T};
      5'd27: w = '{OP_DEADZONE, CND_NEXT, STEP_WAIT, SEL_T, SEL_ZERO, G_DT, DST_VE};
      // hand the result to the output register
      5'd28: w = '{OP_EMIT, CND_WAIT_OUT, STEP_WAIT, SEL_ZERO, SEL_ZERO, G_DT, DST_NONE};
      default: w = '{OP_NOP, CND_GOTO, STEP_WAIT, SEL_ZERO, SEL_ZERO, G_DT, DST_NONE};
    endcase
    return w;
  endfunction

endpackage

// ----- design/height_alpha_beta_filter.sv -----
// height_alpha_beta_filter: fixed-gain alpha-beta height filter, microcoded
// sequencer over one shared split multiplier, adder and limiter
// depends on hab_pkg
// program: 29 steps that run every product through the one shared multiplier
//   in two halves
// input taken only at step 0; a finished word waits in the output register
// reset (synchronous, rst_n low): registers to defaults, state to zero
module height_alpha_beta_filter #(
  parameter int FRAC_BITS  = hab_pkg::DEF_FRAC_BITS,
  parameter int DATA_WIDTH = hab_pkg::DEF_DATA_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_wen,
  input  logic [hab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hab_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hab_pkg::IN_DATA_W-1:0]     in_tdata,   // height, elapsed_time
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // predicted_height, corrected_height, corrected_velocity
  output logic [hab_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int DW = DATA_WIDTH;
  // headroom for sums of products before saturation
  localparam int EW = DATA_WIDTH + 16;
  // multiplier magnitude is DW+1 bits, split in two halves
  localparam int ML = (DATA_WIDTH + 2) / 2;
  localparam int MH = DATA_WIDTH + 1 - ML;
  localparam int PW = DATA_WIDTH + 1 + hab_pkg::GAIN_W;

  localparam logic signed [EW-1:0] DMAX_E = {{(EW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [EW-1:0] DMIN_E = ~DMAX_E;
  localparam logic signed [EW-1:0] S32MAX_E = {{(EW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [EW-1:0] S32MIN_E = ~S32MAX_E;
  localparam logic [PW-1:0] RND_HALF = PW'(1) << (FRAC_BITS - 1);

  // saturate into DW signed bits
  function automatic logic signed [DW-1:0] sat_dw(input logic signed [EW-1:0] x);
    logic signed [EW-1:0] y;
    y = x;
    if (x > DMAX_E) y = DMAX_E;
    if (x < DMIN_E) y = DMIN_E;
    return y[DW-1:0];
  endfunction

  // saturate a state value onto a 32 bit output field
  function automatic logic [hab_pkg::OUT_W-1:0] sat_out(input logic signed [DW-1:0] x);
    logic signed [EW-1:0] y;
    y = EW'(x);
    if (y > S32MAX_E) y = S32MAX_E;
    if (y < S32MIN_E) y = S32MIN_E;
    return y[hab_pkg::OUT_W-1:0];
  endfunction

  // configuration registers
  logic [16:0] pos_gain_r;
  logic [19:0] vel_gain_r;
  logic [16:0] vel_scale_r;
  logic [16:0] blend_r;
  logic [30:0] max_speed_r;
  logic [30:0] deadzone_r;
  logic [15:0] timeout_r;

  // filter state and working registers
  logic signed [DW-1:0] pe_r, pe_nxt;     // position estimate
  logic signed [DW-1:0] ve_r, ve_nxt;     // velocity estimate
  logic signed [DW-1:0] vs_r, vs_nxt;     // smoothed velocity
  logic signed [DW-1:0] h_r;              // measured height
  logic [hab_pkg::TIME_W-1:0] dt_r;       // elapsed time
  logic signed [DW-1:0] xp_r, xp_nxt;     // prediction
  logic signed [DW-1:0] in_r, in_nxt;     // innovation
  logic signed [DW:0]   t_r, t_nxt;       // scratch, holds an unsaturated difference
  logic signed [EW-1:0] q_r, q_nxt;       // rounded product
  logic [PW-1:0]        acc_r, acc_nxt;   // product magnitude accumulator
  logic                 neg_r, neg_nxt;   // product sign

  logic [hab_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                       out_valid_r;
  logic [hab_pkg::OUT_DATA_W-1:0] out_data_r;

  hab_pkg::hab_uword_t uw;
  logic signed [EW-1:0] opa, opb, res, lim_e, mag;
  logic [hab_pkg::GAIN_W-1:0] gain;
  logic [DW:0] mmag;
  logic [ML+hab_pkg::GAIN_W-1:0] prod_lo;
  logic [MH+hab_pkg::GAIN_W-1:0] prod_hi;
  logic [PW-1:0] rnd_sum, rnd_sh;
  logic [EW-1:0] qmag;
  logic in_acc, out_busy, stall, timed_out;

  assign uw        = hab_pkg::hab_ucode(step_r);
  assign in_tready = (step_r == hab_pkg::STEP_WAIT);
  assign in_acc    = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  // strict compare: a gap equal to the timeout keeps the velocity
  assign timed_out = (dt_r > timeout_r);

  // configuration writes, masked to register width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_gain_r  <= hab_pkg::RST_POS_GAIN;
      vel_gain_r  <= hab_pkg::RST_VEL_GAIN;
      vel_scale_r <= hab_pkg::RST_VEL_SCALE;
      blend_r     <= hab_pkg::RST_BLEND;
      max_speed_r <= hab_pkg::RST_MAX_SPEED;
      deadzone_r  <= hab_pkg::RST_DEADZONE;
      timeout_r   <= hab_pkg::RST_TIMEOUT;
    end else if (cfg_wen) begin
      case (cfg_index)
        hab_pkg::REG_POS_GAIN:  pos_gain_r  <= cfg_wdata[16:0];
        hab_pkg::REG_VEL_GAIN:  vel_gain_r  <= cfg_wdata[19:0];
        hab_pkg::REG_VEL_SCALE: vel_scale_r <= cfg_wdata[16:0];
        hab_pkg::REG_BLEND:     blend_r     <= cfg_wdata[16:0];
        hab_pkg::REG_MAX_SPEED: max_speed_r <= cfg_wdata;
        hab_pkg::REG_DEADZONE:  deadzone_r  <= cfg_wdata;
        hab_pkg::REG_TIMEOUT:   timeout_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // operand a mux
  always_comb begin
    case (uw.a_sel)
      hab_pkg::SEL_PE: opa = EW'(pe_r);
      hab_pkg::SEL_VE: opa = EW'(ve_r);
      hab_pkg::SEL_VS: opa = EW'(vs_r);
      hab_pkg::SEL_H:  opa = EW'(h_r);
      hab_pkg::SEL_XP: opa = EW'(xp_r);
      hab_pkg::SEL_IN: opa = EW'(in_r);
      hab_pkg::SEL_T:  opa = EW'(t_r);
      hab_pkg::SEL_Q:  opa = q_r;
      // velocity for the prediction, zero after a long gap
      hab_pkg::SEL_VP: opa = timed_out ? '0 : EW'(vs_r);
      default:         opa = '0;
    endcase
  end

  // operand b mux
  always_comb begin
    case (uw.b_sel)
      hab_pkg::SEL_PE: opb = EW'(pe_r);
      hab_pkg::SEL_VE: opb = EW'(ve_r);
      hab_pkg::SEL_VS: opb = EW'(vs_r);
      hab_pkg::SEL_H:  opb = EW'(h_r);
      hab_pkg::SEL_XP: opb = EW'(xp_r);
      hab_pkg::SEL_IN: opb = EW'(in_r);
      hab_pkg::SEL_T:  opb = EW'(t_r);
      hab_pkg::SEL_Q:  opb = q_r;
      hab_pkg::SEL_VP: opb = timed_out ? '0 : EW'(vs_r);
      default:         opb = '0;
    endcase
  end

  // gain mux, all gains zero-extended to the multiplier width
  always_comb begin
    case (uw.g_sel)
      hab_pkg::G_DT:     gain = hab_pkg::GAIN_W'(dt_r);
      hab_pkg::G_BLEND:  gain = hab_pkg::GAIN_W'(blend_r);
      hab_pkg::G_POS:    gain = hab_pkg::GAIN_W'(pos_gain_r);
      hab_pkg::G_VEL:    gain = vel_gain_r;
      hab_pkg::G_VSCALE: gain = hab_pkg::GAIN_W'(vel_scale_r);
      default:           gain = '0;
    endcase
  end

  // sign-magnitude multiplier, low half then high half of the magnitude
  assign mmag    = (opa < 0) ? (DW+1)'(0) - opa[DW:0] : opa[DW:0];
  assign prod_lo = mmag[ML-1:0] * gain;
  assign prod_hi = mmag[DW:ML] * gain;
  // round to nearest, halves away from zero
  assign rnd_sum = acc_r + RND_HALF;
  assign rnd_sh  = rnd_sum >> FRAC_BITS;
  assign qmag    = rnd_sh[EW-1:0];

  // clamp limit, held to the largest state value
  assign lim_e = (signed'(EW'(max_speed_r)) > DMAX_E) ? DMAX_E : signed'(EW'(max_speed_r));
  assign mag   = (opa < 0) ? -opa : opa;

  // alu result for steps that write a state register
  always_comb begin
    case (uw.op)
      hab_pkg::OP_ADD_SAT: res = EW'(sat_dw(opa + opb));
      hab_pkg::OP_SUB_SAT: res = EW'(sat_dw(opa - opb));
      // blend difference kept unsaturated
      hab_pkg::OP_SUB_RAW: res = opa - opb;
      hab_pkg::OP_CLAMP: begin
        if (opa > lim_e) res = lim_e;
        else if (opa < -lim_e) res = -lim_e;
        else res = opa;
      end
      hab_pkg::OP_DEADZONE: res = (mag < signed'(EW'(deadzone_r))) ? '0 : opa;
      default: res = '0;
    endcase
  end

  // datapath register updates
  always_comb begin
    pe_nxt  = pe_r;
    ve_nxt  = ve_r;
    vs_nxt  = vs_r;
    xp_nxt  = xp_r;
    in_nxt  = in_r;
    t_nxt   = t_r;
    q_nxt   = q_r;
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    case (uw.op)
      hab_pkg::OP_MUL_LO: begin
        acc_nxt = PW'(prod_lo);
        neg_nxt = (opa < 0);
      end
      hab_pkg::OP_MUL_HI: acc_nxt = acc_r + (PW'(prod_hi) << ML);
      hab_pkg::OP_MUL_RND: q_nxt = neg_r ? -signed'(qmag) : signed'(qmag);
      default: ;
    endcase
    case (uw.dst)
      hab_pkg::DST_PE: pe_nxt = res[DW-1:0];
      hab_pkg::DST_VE: ve_nxt = res[DW-1:0];
      hab_pkg::DST_VS: vs_nxt = res[DW-1:0];
      hab_pkg::DST_XP: xp_nxt = res[DW-1:0];
      hab_pkg::DST_IN: in_nxt = res[DW-1:0];
      hab_pkg::DST_T:  t_nxt  = res[DW:0];
      default: ;
    endcase
  end

  // step counter with conditional holds and jumps
  always_comb begin
    stall = ((uw.cond == hab_pkg::CND_WAIT_IN) && !in_tvalid) ||
            ((uw.cond == hab_pkg::CND_WAIT_OUT) && out_busy);
    if (stall) step_nxt = step_r;
    else if ((uw.cond == hab_pkg::CND_GOTO) || (uw.cond == hab_pkg::CND_WAIT_OUT))
      step_nxt = uw.target;
    else step_nxt = step_r + 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= hab_pkg::STEP_WAIT;
      out_valid_r <= 1'b0;
      pe_r        <= '0;
      ve_r        <= '0;
      vs_r        <= '0;
    end else begin
      step_r <= step_nxt;
      pe_r   <= pe_nxt;
      ve_r   <= ve_nxt;
      vs_r   <= vs_nxt;
      if ((uw.op == hab_pkg::OP_EMIT) && !out_busy) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    xp_r  <= xp_nxt;
    in_r  <= in_nxt;
    t_r   <= t_nxt;
    q_r   <= q_nxt;
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
    if (in_acc) begin
      h_r  <= sat_dw(EW'(signed'(in_tdata[hab_pkg::HEIGHT_W-1:0])));
      dt_r <= in_tdata[hab_pkg::IN_DATA_W-1:hab_pkg::HEIGHT_W];
    end
    if ((uw.op == hab_pkg::OP_EMIT) && !out_busy)
      out_data_r <= {sat_out(ve_r), sat_out(pe_r), sat_out(xp_r)};
  end

  // an accepted word always starts the program at the first multiply step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (step_r == hab_pkg::STEP_WAIT + 1'b1))
    else $error("program did not start after input word");

  // the high partial product always follows the low one
  a_mul_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == hab_pkg::OP_MUL_HI) |-> ($past(uw.op) == hab_pkg::OP_MUL_LO))
    else $error("high partial product without low half");

  // a new output word comes only from the emit step
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(uw.op) == hab_pkg::OP_EMIT))
    else $error("output word raised outside the emit step");

  // the step counter stays within the program
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= hab_pkg::STEP_LAST)
    else $error("step counter left the program");

endmodule

// ----- bench/hab_estimate_board.sv -----
`timescale 1ns / 1ps
// hab_estimate_board: expected-result store and bit-exact predictor for the
// height alpha-beta filter bench
// depends on hab_pkg for widths, register indexes and reset values
package hab_bench_pkg;
  import hab_pkg::*;

  // packed in the same order as out_tdata, predicted height in the lowest bits
  typedef struct packed {
    logic signed [31:0] velocity;
    logic signed [31:0] corrected;
    logic signed [31:0] predicted;
  } estimate_t;

  class height_estimate_board;
    logic [16:0] pos_gain;
    logic [19:0] vel_gain;
    logic [16:0] vel_scale;
    logic [16:0] blend;
    logic [30:0] speed_limit;
    logic [30:0] deadzone;
    logic [15:0] timeout;
    longint pos_est;
    longint vel_est;
    longint vel_smooth;
    estimate_t pending[$];
    int unsigned checked;
    int unsigned mismatches;
    int unsigned strays;
    int unsigned reported;

    function new();
      pos_gain = RST_POS_GAIN;
      vel_gain = RST_VEL_GAIN;
      vel_scale = RST_VEL_SCALE;
      blend = RST_BLEND;
      speed_limit = RST_MAX_SPEED;
      deadzone = RST_DEADZONE;
      timeout = RST_TIMEOUT;
      pos_est = 0;
      vel_est = 0;
      vel_smooth = 0;
      checked = 0;
      mismatches = 0;
      strays = 0;
      reported = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_POS_GAIN:  pos_gain = value[16:0];
        REG_VEL_GAIN:  vel_gain = value[19:0];
        REG_VEL_SCALE: vel_scale = value[16:0];
        REG_BLEND:     blend = value[16:0];
        REG_MAX_SPEED: speed_limit = value[30:0];
        REG_DEADZONE:  deadzone = value[30:0];
        REG_TIMEOUT:   timeout = value[15:0];
        default: ;
      endcase
    endfunction

    // saturate to the 32-bit signed datapath
    function longint clip(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // product with an unsigned q.16 factor, rounded half away from zero
    function longint scale_q16(input longint a, input logic [19:0] g);
      logic [63:0] mag;
      logic [95:0] prod;
      longint q;
      mag = (a < 0) ? -a : a;
      prod = 96'(mag) * 96'(g) + 96'd32768;
      q = longint'(prod[79:16]);
      return (a < 0) ? -q : q;
    endfunction

    function longint limit_rate(input longint v);
      longint lim;
      longint mag;
      lim = longint'({33'd0, speed_limit});
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      mag = (v < 0) ? -v : v;
      if (mag < longint'({33'd0, deadzone})) v = 0;
      return v;
    endfunction

    // one filter step for an accepted input word
    function void take_reading(input logic signed [31:0] h, input logic [15:0] dt);
      longint vp, xpred, v, innov, xpost, corr, vpost;
      estimate_t e;
      vp = (dt > timeout) ? 64'sd0 : vel_smooth;
      xpred = clip(pos_est + scale_q16(vp, dt));
      v = limit_rate(vel_est);
      vel_smooth = clip(vel_smooth + scale_q16(v - vel_smooth, blend));
      innov = clip(longint'(h) - xpred);
      xpost = clip(xpred + scale_q16(innov, pos_gain));
      corr = clip(scale_q16(innov, vel_gain));
      corr = clip(scale_q16(corr, vel_scale));
      vpost = limit_rate(clip(vel_smooth + corr));
      pos_est = xpost;
      vel_est = vpost;
      e.predicted = 32'(xpred);
      e.corrected = 32'(xpost);
      e.velocity = 32'(vpost);
      pending.push_back(e);
    endfunction

    function void match_estimate(input logic [OUT_DATA_W-1:0] word);
      estimate_t got;
      estimate_t want;
      got = estimate_t'(word);
      if (pending.size() == 0) begin
        strays++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result word: predicted %0d corrected %0d velocity %0d",
                   got.predicted, got.corrected, got.velocity);
        end
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.predicted !== want.predicted || got.corrected !== want.corrected ||
          got.velocity !== want.velocity) begin
        mismatches++;
        if (reported < 10) begin
          reported++;
          $display("mismatch on result %0d (expected/actual): predicted %0d/%0d", checked,
                   want.predicted, got.predicted);
          $display("  corrected %0d/%0d velocity %0d/%0d", want.corrected, got.corrected,
                   want.velocity, got.velocity);
        end
      end
    endfunction
  endclass

endpackage

// ----- bench/height_alpha_beta_filter_tb.sv -----
`timescale 1ns / 1ps
// height_alpha_beta_filter_tb: drives height words through the filter under
// several register settings and checks every result word against a predictor
// depends on hab_pkg and hab_bench_pkg (hab_estimate_board.sv)
module height_alpha_beta_filter_tb;
  import hab_pkg::*;
  import hab_bench_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving on either side
  localparam int HOLD_CYCLES    = 800;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 40;    // quiet time after the last result is back

  typedef enum int {SET_CEILING, SET_FLOOR, SET_OVERRANGE, SET_RANDOM} setting_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // height, elapsed_time
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // predicted, corrected height, velocity

  height_estimate_board board;

  // receiver hold-off request, raised by the main sequence, cleared by the receiver
  bit          hold_request = 1'b0;
  int unsigned holds_done = 0;
  int unsigned settings_used = 0;
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;

  // synthetic flight path that the well-formed readings follow
  longint track_h = 0;
  longint track_rate = 0;

  always #5 clk = ~clk;

  height_alpha_beta_filter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // monitor: every accepted input word is predicted, every result word checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        board.take_reading(in_tdata[31:0], in_tdata[47:32]);
        words_sent++;
      end
      if (out_tvalid && out_tready)
        board.match_estimate(out_tdata);
    end
  end

  // watchdog: a run that stops moving words is a failure
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, board.pending.size());
      $display("height_alpha_beta_filter_tb: FAIL");
      $finish;
    end
  end

  // receiver: changes its stall pattern every so often, and on request holds
  // off for a long stretch so the block backs up into the input side
  initial begin
    int mode;
    int stretch;
    int unsigned beat;
    beat = 0;
    forever begin
      if (hold_request) begin
        @(negedge clk);
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        holds_done++;
      end else begin
        mode = $urandom_range(0, 3);
        stretch = $urandom_range(20, 200);
        repeat (stretch) begin
          @(negedge clk);
          beat++;
          case (mode)
            0: out_tready = 1'b1;                            // no stalls at all
            1: out_tready = 1'($urandom_range(0, 1));         // coin toss
            2: out_tready = (beat % 7) < 4;                   // fixed duty pattern
            default: out_tready = ($urandom_range(0, 15) == 0); // mostly stalled
          endcase
        end
      end
    end
  end

  // offer one word and hold it until the block takes it
  task automatic offer_reading(input logic signed [31:0] h, input logic [15:0] dt);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {dt, h};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wen = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wen = 1'b0;
    board.write_reg(idx, value);
  endtask

  task automatic program_all(input logic [CFG_DATA_W-1:0] pg, input logic [CFG_DATA_W-1:0] vg,
                             input logic [CFG_DATA_W-1:0] vs, input logic [CFG_DATA_W-1:0] bw,
                             input logic [CFG_DATA_W-1:0] ms, input logic [CFG_DATA_W-1:0] dz,
                             input logic [CFG_DATA_W-1:0] to);
    write_reg(REG_POS_GAIN, pg);
    write_reg(REG_VEL_GAIN, vg);
    write_reg(REG_VEL_SCALE, vs);
    write_reg(REG_BLEND, bw);
    write_reg(REG_MAX_SPEED, ms);
    write_reg(REG_DEADZONE, dz);
    write_reg(REG_TIMEOUT, to);
    settings_used++;
  endtask

  // random register value: mostly plausible, sometimes an edge or garbage in
  // the bits above the register width
  function automatic logic [CFG_DATA_W-1:0] pick_value(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_DATA_W-1:0] ceiling;
    logic [CFG_DATA_W-1:0] at_reset;
    int r;
    case (idx)
      REG_POS_GAIN:  begin ceiling = 65536;        at_reset = RST_POS_GAIN; end
      REG_VEL_GAIN:  begin ceiling = 1048575;      at_reset = RST_VEL_GAIN; end
      REG_VEL_SCALE: begin ceiling = 65536;        at_reset = RST_VEL_SCALE; end
      REG_BLEND:     begin ceiling = 65536;        at_reset = RST_BLEND; end
      REG_MAX_SPEED: begin ceiling = 31'h7FFFFFFF; at_reset = RST_MAX_SPEED; end
      REG_DEADZONE:  begin ceiling = 31'h7FFFFFFF; at_reset = RST_DEADZONE; end
      default:       begin ceiling = 65535;        at_reset = RST_TIMEOUT; end
    endcase
    r = $urandom_range(0, 9);
    case (r)
      0: return at_reset;
      1: return '0;
      2: return ceiling;
      3: return 31'($urandom());
      default: begin
        if (idx == REG_MAX_SPEED) return CFG_DATA_W'($urandom_range(0, 1 << 22));
        if (idx == REG_DEADZONE) return CFG_DATA_W'($urandom_range(0, 1 << 12));
        return CFG_DATA_W'($urandom_range(0, ceiling));
      end
    endcase
  endfunction

  task automatic apply_setting(input setting_t kind);
    case (kind)
      SET_CEILING:
        program_all(65536, 1048575, 65536, 65536, 31'h7FFFFFFF, 0, 65535);
      SET_FLOOR:
        program_all(0, 0, 0, 0, 0, 0, 0);
      SET_OVERRANGE: begin
        // every bit set: gains and blend weight past unity, then a usable deadzone
        program_all('1, '1, '1, '1, '1, '1, '1);
        write_reg(REG_DEADZONE, 300);
      end
      default:
        program_all(pick_value(REG_POS_GAIN), pick_value(REG_VEL_GAIN),
                    pick_value(REG_VEL_SCALE), pick_value(REG_BLEND),
                    pick_value(REG_MAX_SPEED), pick_value(REG_DEADZONE),
                    pick_value(REG_TIMEOUT));
    endcase
  endtask

  // wait until every expected word is back and the sequencer is back at rest
  task automatic drain_block();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // next reading: mostly a plausible flight path, the rest noise and edges
  task automatic next_reading(output logic signed [31:0] h, output logic [15:0] dt);
    int r;
    int pick;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      dt = 16'($urandom_range(600, 6600));
      track_rate += longint'($urandom_range(0, 20000)) - 10000;
      if (track_rate > 327680) track_rate = 327680;
      if (track_rate < -327680) track_rate = -327680;
      track_h += (track_rate * longint'(dt)) >>> 16;
      track_h += longint'($urandom_range(0, 4000)) - 2000;
      track_h = board.clip(track_h);
      h = 32'(track_h);
    end else if (r < 80) begin
      // jump in the path with an uneven gap
      dt = 16'($urandom_range(0, 65535));
      track_h = board.clip(track_h + longint'($urandom_range(0, 1 << 24)) - (1 << 23));
      h = 32'(track_h);
    end else if (r < 90) begin
      dt = 16'($urandom_range(0, 65535));
      h = $urandom();
    end else begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: h = 32'sh7FFFFFFF;
        1: h = 32'sh80000000;
        2: h = 32'sh7FFFFFFF - $urandom_range(0, 255);
        3: h = 32'sh80000000 + $urandom_range(0, 255);
        4: h = '0;
        default: h = -32'sd1;
      endcase
      pick = $urandom_range(0, 3);
      case (pick)
        0: dt = '0;
        1: dt = 16'hFFFF;
        2: dt = board.timeout;                  // at the timeout: velocity kept
        default: dt = 16'(board.timeout + 1'b1); // just past it: velocity dropped
      endcase
    end
  endtask

  // random readings in bursts, with gaps of every length around the program
  task automatic stream_readings(input int count);
    int left;
    int burst;
    logic signed [31:0] h;
    logic [15:0] dt;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) begin
        next_reading(h, dt);
        offer_reading(h, dt);
      end
      left -= burst;
      if ($urandom_range(0, 3) != 0)
        pause_sender($urandom_range(1, 40));
    end
  endtask

  initial begin
    int phase;
    board = new();

    // synchronous reset, held low and then released
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed words at the reset settings: extremes, saturation, both sides
    // of the timeout and an end-of-range gap
    offer_reading(32'sd0, 16'd0);
    offer_reading(32'sh7FFFFFFF, 16'd0);
    offer_reading(32'sh7FFFFFFF, 16'd16384);
    offer_reading(32'sh80000000, 16'hFFFF);
    offer_reading(32'sh80000000, 16'd16384);
    offer_reading(32'sh80000000, 16'd16385);
    offer_reading(32'sh00010000, 16'd655);
    offer_reading(32'sh00010000, 16'd655);
    offer_reading(-32'sd1, 16'hFFFF);
    offer_reading(32'sh12345678, 16'd1);
    offer_reading(32'sh12345678, 16'd16384);
    offer_reading(32'sh12345000, 16'd16385);
    drain_block();

    // gains and blend weight above their nominal range, wide bits masked
    apply_setting(SET_OVERRANGE);
    offer_reading(32'sh7FFFFFFF, 16'd0);
    offer_reading(32'sh80000000, 16'd1000);
    offer_reading(32'sh80000000, 16'hFFFF);
    offer_reading(32'sh00001000, 16'd1000);
    offer_reading(32'sh7FFFFFFF, 16'hFFFF);
    offer_reading(-32'sd2, 16'd32768);
    offer_reading(32'sd3, 16'd7);
    offer_reading(32'sh40000000, 16'd2000);
    drain_block();

    apply_setting(SET_CEILING);
    stream_readings(120);
    drain_block();

    apply_setting(SET_FLOOR);
    stream_readings(80);
    drain_block();

    // random settings; one phase runs with the receiver held off
    for (phase = 0; phase < 9; phase++) begin
      apply_setting(SET_RANDOM);
      if (phase == 3) hold_request = 1'b1;
      stream_readings(150);
      drain_block();
    end

    // ending: nothing outstanding, then a settle period of quiet
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d height words over %0d register settings, %0d results checked",
             words_sent, settings_used + 1, board.checked);
    $display("receiver hold-offs: %0d, mismatches %0d, unexpected %0d, missing %0d",
             holds_done, board.mismatches, board.strays, board.pending.size());
    if (board.mismatches == 0 && board.strays == 0 && board.pending.size() == 0)
      $display("height_alpha_beta_filter_tb: PASS");
    else
      $display("height_alpha_beta_filter_tb: FAIL");
    $finish;
  end

endmodule
